FILE: src/arc_point_generator_unit_defines.svh
// assertion macros used by the checker file
`ifndef ARC_POINT_GENERATOR_UNIT_DEFINES_SVH
`define ARC_POINT_GENERATOR_UNIT_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define APG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define APG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/apg_pkg.sv
package apg_pkg;

	localparam int COORD_W           = 48;
	localparam int ANG_IN_W          = 17;
	localparam int ANGLE_FRAC_BITS   = 8;
	localparam int CORDIC_ITERATIONS = 20;

	localparam int FULL_UNITS = 360 << ANGLE_FRAC_BITS;
	localparam int STEP_UNITS = 5 << ANGLE_FRAC_BITS;

	// degree units to 2^32 per turn: a full turn is 45 << 11 units, so the binary
	// angle is (t * 2^21 + 22) / 45; t is split as 45*a + r and both divisions
	// by 45 use a reciprocal multiply that is exact over the operand range
	localparam logic [5:0]  DIV_ODD  = 6'd45;
	localparam logic [26:0] DIV_BIAS = 27'd22;
	localparam logic [17:0] DIV_M1   = 18'd186414;     // ceil(2^23 / 45), operand below 2^17
	localparam logic [27:0] DIV_M2   = 28'd190887436;  // ceil(2^33 / 45), operand below 2^27

	// cordic datapath width, q2.30 plus headroom
	localparam int CW = 33;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [4:0] DIV_LAST = 5'd2;
	localparam logic [4:0] ROT_LAST = 5'(CORDIC_ITERATIONS - 1);

	localparam logic signed [50:0] SAT_MAX = 51'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [50:0] SAT_MIN = -51'sh0_8000_0000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0]  center_x;
		logic signed [COORD_W-1:0]  center_y;
		logic signed [COORD_W-1:0]  radius_signed;
		logic        [ANG_IN_W-1:0] start_deg;
		logic        [ANG_IN_W-1:0] finish_deg;
		logic signed [COORD_W-1:0]  z_level;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic                      second_valid;
		logic                      last_pair;
	} out_word_t;

	typedef struct packed {
		logic       load;
		logic       vtx_start;
		logic       div_step;
		logic       rot_init;
		logic       rot_step;
		logic       qmap;
		logic       mul_lo;
		logic       mul_hi;
		logic       rnd;
		logic       add;
		logic       axis_y;
		logic       hold;
		logic       emit_pair;
		logic       emit_flush;
		logic       advance;
		logic [4:0] idx;
	} apg_cmd_t;

	typedef struct packed {
		logic final_vtx;
		logic held_present;
		logic out_free;
	} apg_status_t;

	// arctangent of 2^-i as a fraction of a turn, 2^32 per turn
	function automatic logic [31:0] atan_val(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			5'd31: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: src/arc_point_generator_unit.sv
// arc point generator: one arc word in, a run of vertex-pair words out
// input channel in_valid/in_ready/in_data carries center, signed radius,
// start and finish angles (1/256 degree) and z; a negative radius walks clockwise
// vertices fall every 5 degrees plus a closing vertex at the finish angle,
// packed two per output word; an odd last vertex goes out alone with
// second_valid low, and last_pair marks the final word of each arc
// one arc is worked on at a time: in_ready is high only while idle
// each vertex passes through the angle conversion (reciprocal multiplies),
// the iterative cordic rotation and the shared 24x32 multiplier, used four
// times for x and y
// the output word sits in a register; if the receiver stalls, the engine
// keeps working until its next word is ready and then waits for that register
// reset clears the sequencer and drops out_valid; no word is in flight after it
module arc_point_generator_unit import apg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// command and status between sequencer and datapath
	apg_cmd_t    cmd;
	apg_status_t status;

	apg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// angle conversion, cordic, scaler and pair/output registers
	apg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: src/apg_ctrl.sv
module apg_ctrl import apg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  apg_status_t status,
	output apg_cmd_t    cmd
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_VSTART = 16'b0000_0000_0000_0010,
		S_DIV    = 16'b0000_0000_0000_0100,
		S_CINIT  = 16'b0000_0000_0000_1000,
		S_ROT    = 16'b0000_0000_0001_0000,
		S_QMAP   = 16'b0000_0000_0010_0000,
		S_MXL    = 16'b0000_0000_0100_0000,
		S_MXH    = 16'b0000_0000_1000_0000,
		S_RX     = 16'b0000_0001_0000_0000,
		S_AX     = 16'b0000_0010_0000_0000,
		S_MYL    = 16'b0000_0100_0000_0000,
		S_MYH    = 16'b0000_1000_0000_0000,
		S_RY     = 16'b0001_0000_0000_0000,
		S_AY     = 16'b0010_0000_0000_0000,
		S_VDONE  = 16'b0100_0000_0000_0000,
		S_FLUSH  = 16'b1000_0000_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_VSTART;
				end
			end
			S_VSTART: begin
				cmd.vtx_start = 1'b1;
				cnt_d         = '0;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_CINIT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_CINIT: begin
				cmd.rot_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_ROT;
			end
			S_ROT: begin
				cmd.rot_step = 1'b1;
				if (cnt_q == ROT_LAST) begin
					cnt_d   = '0;
					state_d = S_QMAP;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_QMAP: begin
				cmd.qmap = 1'b1;
				state_d  = S_MXL;
			end
			S_MXL: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MXH;
			end
			S_MXH: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_RX;
			end
			S_RX: begin
				cmd.rnd = 1'b1;
				state_d = S_AX;
			end
			S_AX: begin
				cmd.add = 1'b1;
				state_d = S_MYL;
			end
			S_MYL: begin
				cmd.mul_lo = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_MYH;
			end
			S_MYH: begin
				cmd.mul_hi = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_RY;
			end
			S_RY: begin
				cmd.rnd    = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_AY;
			end
			S_AY: begin
				cmd.add    = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_VDONE;
			end
			S_VDONE: begin
				if (!status.held_present) begin
					cmd.hold = 1'b1;
					if (status.final_vtx) begin
						state_d = S_FLUSH;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_VSTART;
					end
				end else if (status.out_free) begin
					cmd.emit_pair = 1'b1;
					if (status.final_vtx) begin
						state_d = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_VSTART;
					end
				end
			end
			S_FLUSH: begin
				if (status.out_free) begin
					cmd.emit_flush = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: src/apg_datapath.sv
module apg_datapath import apg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  apg_cmd_t    cmd,
	input  in_word_t    in_data,
	output apg_status_t status,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	// arc parameters
	logic signed [COORD_W-1:0] cx_q, cy_q, z_q;
	logic        [COORD_W-1:0] rmag_q;
	logic                      cw_q;
	logic signed [18:0]        theta_q;
	logic        [17:0]        finish_q;
	logic                      final_q;

	// angle conversion
	logic [16:0] rem_q;
	logic [10:0] aq_q;
	logic [31:0] quot_q;

	// cordic
	logic signed [CW-1:0] x_q, y_q, za_q;
	logic [1:0]           quad_q;
	logic [31:0]          cmag_q, smag_q;
	logic                 cneg_q, sneg_q;

	// scaling and vertex
	logic [55:0]               plo_q, phi_q;
	logic [49:0]               r_q;
	logic signed [COORD_W-1:0] vx_q, vy_q;
	logic signed [COORD_W-1:0] held_x_q, held_y_q;
	logic                      held_present_q;
	logic                      out_valid_q;
	out_word_t                 out_q;

	logic [16:0]          start_r, finish_r;
	logic [17:0]          finish_e;
	logic                 more;
	logic [17:0]          units;
	logic [16:0]          t_units;
	logic [34:0]          div_p1;
	logic [26:0]          div_n2;
	logic [54:0]          div_p2;
	logic signed [CW-1:0] xs, ys, at;
	logic signed [CW-1:0] c_val, s_val;
	logic [31:0]          mul_m;
	logic [80:0]          rsum;
	logic signed [50:0]   base_e, r_e, v_sum, v_sat;

	assign start_r  = (in_data.start_deg >= 17'(FULL_UNITS))
		? in_data.start_deg - 17'(FULL_UNITS) : in_data.start_deg;
	assign finish_r = (in_data.finish_deg >= 17'(FULL_UNITS))
		? in_data.finish_deg - 17'(FULL_UNITS) : in_data.finish_deg;
	assign finish_e = (start_r > finish_r)
		? {1'b0, finish_r} + 18'(FULL_UNITS) : {1'b0, finish_r};

	// still stepping toward finish
	assign more = cw_q ? (theta_q > $signed({1'b0, finish_q}))
		: (theta_q < $signed({1'b0, finish_q}));

	assign units   = more ? theta_q[17:0] : finish_q;
	assign t_units = (units >= 18'(FULL_UNITS)) ? 17'(units - 18'(FULL_UNITS)) : units[16:0];

	// coarse quotient t / 45, then fine quotient of the remainder shifted up
	assign div_p1 = 35'(rem_q) * 35'(DIV_M1);
	assign div_n2 = {rem_q[5:0], 21'b0} + DIV_BIAS;
	assign div_p2 = 55'(div_n2) * 55'(DIV_M2);

	assign xs = x_q >>> cmd.idx;
	assign ys = y_q >>> cmd.idx;
	assign at = $signed({1'b0, atan_val(cmd.idx)});

	always_comb begin
		unique case (quad_q)
			2'd0: begin c_val = x_q;  s_val = y_q;  end
			2'd1: begin c_val = -y_q; s_val = x_q;  end
			2'd2: begin c_val = -x_q; s_val = -y_q; end
			2'd3: begin c_val = y_q;  s_val = -x_q; end
		endcase
	end

	assign mul_m = cmd.axis_y ? smag_q : cmag_q;
	assign rsum  = {1'b0, phi_q, 24'b0} + {25'b0, plo_q} + 81'(1 << 29);

	assign base_e = cmd.axis_y ? 51'(cy_q) : 51'(cx_q);
	assign r_e    = $signed({1'b0, r_q});
	assign v_sum  = (cmd.axis_y ? sneg_q : cneg_q) ? base_e - r_e : base_e + r_e;

	always_comb begin
		priority if (v_sum > SAT_MAX) begin
			v_sat = SAT_MAX;
		end else if (v_sum < SAT_MIN) begin
			v_sat = SAT_MIN;
		end else begin
			v_sat = v_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q     <= in_data.center_x;
			cy_q     <= in_data.center_y;
			z_q      <= in_data.z_level;
			cw_q     <= in_data.radius_signed[COORD_W-1];
			rmag_q   <= in_data.radius_signed[COORD_W-1]
				? COORD_W'(-in_data.radius_signed) : COORD_W'(in_data.radius_signed);
			finish_q <= finish_e;
			theta_q  <= in_data.radius_signed[COORD_W-1]
				? $signed({2'b0, start_r} + 19'(FULL_UNITS)) : $signed({2'b0, start_r});
		end
		if (cmd.advance) begin
			theta_q <= cw_q ? theta_q - 19'(STEP_UNITS) : theta_q + 19'(STEP_UNITS);
		end
		if (cmd.vtx_start) begin
			final_q <= !more;
			rem_q   <= t_units;
			quot_q  <= '0;
		end
		if (cmd.div_step) begin
			unique case (cmd.idx)
				5'd0: begin
					aq_q <= div_p1[33:23];
				end
				5'd1: begin
					rem_q <= rem_q - 17'(aq_q) * 17'(DIV_ODD);
				end
				default: begin
					quot_q <= {aq_q, div_p2[53:33]};
				end
			endcase
		end
		if (cmd.rot_init) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			za_q   <= $signed({3'b0, quot_q[29:0]});
			quad_q <= quot_q[31:30];
		end
		if (cmd.rot_step) begin
			if (!za_q[CW-1]) begin
				x_q  <= x_q - ys;
				y_q  <= y_q + xs;
				za_q <= za_q - at;
			end else begin
				x_q  <= x_q + ys;
				y_q  <= y_q - xs;
				za_q <= za_q + at;
			end
		end
		if (cmd.qmap) begin
			cneg_q <= c_val[CW-1];
			sneg_q <= s_val[CW-1];
			cmag_q <= c_val[CW-1] ? 32'(-c_val) : 32'(c_val);
			smag_q <= s_val[CW-1] ? 32'(-s_val) : 32'(s_val);
		end
		if (cmd.mul_lo) begin
			plo_q <= 56'(rmag_q[23:0]) * 56'(mul_m);
		end
		if (cmd.mul_hi) begin
			phi_q <= 56'(rmag_q[47:24]) * 56'(mul_m);
		end
		if (cmd.rnd) begin
			r_q <= rsum[79:30];
		end
		if (cmd.add) begin
			if (cmd.axis_y) begin
				vy_q <= v_sat[COORD_W-1:0];
			end else begin
				vx_q <= v_sat[COORD_W-1:0];
			end
		end
		if (cmd.hold) begin
			held_x_q <= vx_q;
			held_y_q <= vy_q;
		end
		if (cmd.emit_pair) begin
			out_q.first_x      <= held_x_q;
			out_q.first_y      <= held_y_q;
			out_q.second_x     <= vx_q;
			out_q.second_y     <= vy_q;
			out_q.vertex_z     <= z_q;
			out_q.second_valid <= 1'b1;
			out_q.last_pair    <= final_q;
		end else if (cmd.emit_flush) begin
			out_q.first_x      <= held_x_q;
			out_q.first_y      <= held_y_q;
			out_q.second_x     <= '0;
			out_q.second_y     <= '0;
			out_q.vertex_z     <= z_q;
			out_q.second_valid <= 1'b0;
			out_q.last_pair    <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_present_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.load || cmd.emit_pair || cmd.emit_flush) begin
				held_present_q <= 1'b0;
			end else if (cmd.hold) begin
				held_present_q <= 1'b1;
			end
			if (cmd.emit_pair || cmd.emit_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.final_vtx    = final_q;
	assign status.held_present = held_present_q;
	assign status.out_free     = !out_valid_q || out_ready;
	assign out_valid           = out_valid_q;
	assign out_data            = out_q;

endmodule

FILE: src/apg_checker.sv
`include "arc_point_generator_unit_defines.svh"

module apg_checker import apg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	`APG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
	`APG_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "word shown during reset")
	`APG_ASSERT(a_one_arc, in_valid && in_ready |=> !in_ready, "second arc taken while busy")
	`APG_ASSERT(a_lone_last, out_valid && !out_data.second_valid |-> out_data.last_pair, "lone vertex before arc end")
	`APG_ASSERT(a_lone_zero, out_valid && !out_data.second_valid |-> out_data.second_x == '0 && out_data.second_y == '0, "lone vertex partner not zero")

endmodule

bind arc_point_generator_unit apg_checker u_apg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
